### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the drum trigger block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### src/dpmt_pkg.sv
// ----------------------------------------------------------------------------
// dpmt_pkg
// Types, constants and the pad note table of the drum pad trigger.
// ----------------------------------------------------------------------------
package dpmt_pkg;

    localparam int PAD_COUNT = 9;
    localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int TIME_W = 32;
    localparam int MS_W = 16;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] RESULT_LIMIT = 5'd27;
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_MIDI_CHANNEL = 3'd0;
    localparam logic [2:0] REG_NORMAL_VEL = 3'd1;
    localparam logic [2:0] REG_ACCENT_VEL = 3'd2;
    localparam logic [2:0] REG_NOTE_LENGTH = 3'd3;
    localparam logic [2:0] REG_GUARD = 3'd4;
    localparam logic [2:0] REG_ACCENT_WIN = 3'd5;

    localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] vel;
    } msg_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } alu_req_t;

    function automatic logic [6:0] pad_note(input logic [PAD_W-1:0] pad);
        logic [6:0] n;
        case (pad)
            4'd0: n = 7'd49;
            4'd1: n = 7'd42;
            4'd2: n = 7'd44;
            4'd3: n = 7'd38;
            4'd4: n = 7'd50;
            4'd5: n = 7'd36;
            4'd6: n = 7'd47;
            4'd7: n = 7'd43;
            4'd8: n = 7'd51;
            default: n = 7'd0;
        endcase
        return n;
    endfunction

endpackage

### src/dpmt_alu.sv
// ----------------------------------------------------------------------------
// dpmt_alu
// Shared 32-bit adder and unsigned comparator used by the guard, accent, note-on, guard-set and end steps.
// ----------------------------------------------------------------------------
module dpmt_alu (
    input  dpmt_pkg::alu_req_t           req,
    output logic [dpmt_pkg::TIME_W-1:0]  sum,
    output logic                         ge
);
    import dpmt_pkg::*;

    logic [TIME_W:0] full;

    assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
                  + {{TIME_W{1'b0}}, req.sub};
    assign sum = full[TIME_W-1:0];
    assign ge = full[TIME_W];

endmodule

### src/drum_pad_to_midi_trigger.sv
// ----------------------------------------------------------------------------
// drum_pad_to_midi_trigger
// Turns pad scans into MIDI note-on and note-off beats.
//
//   Channel  Ports                    Direction  Beat
//   s_       valid/ready + payload    in         one pad scan
//   m_       valid/ready + payload    out        one MIDI message
//   APB      psel/penable/pwrite/...  in/out     register access
//
// Per pad a scan runs the guard check, then the end check alone or the
// accent, note-off, note-on, guard-set and end steps; a flushing scan then
// visits every pad once more. A busy result side stalls the steps. The last
// message of a scan is held back one beat until the sequencer knows nothing
// follows it. Reset clears the registers and all pad state.
// ----------------------------------------------------------------------------
module drum_pad_to_midi_trigger (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dpmt_pkg::PAD_COUNT-1:0]     s_pad_bits,
    input  logic [dpmt_pkg::TIME_W-1:0]        s_time_ms,
    input  logic                               s_flush,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_status_byte,
    output logic [6:0]                         m_note_number,
    output logic [6:0]                         m_velocity,
    output logic                               m_last_message,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dpmt_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import dpmt_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GUARD = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_OFF1  = 3'd3;
    localparam logic [2:0] ST_ON    = 3'd4;
    localparam logic [2:0] ST_GSET  = 3'd5;
    localparam logic [2:0] ST_END   = 3'd6;
    localparam logic [2:0] ST_FLUSH = 3'd7;

    logic [3:0]        chan_reg;
    logic [6:0]        nvel_reg;
    logic [6:0]        avel_reg;
    logic [MS_W-1:0]   len_reg;
    logic [MS_W-1:0]   grdms_reg;
    logic [MS_W-1:0]   win_reg;

    logic [3:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [PAD_W-1:0]  pad_reg, pad_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              acc_reg, acc_next;

    logic [PAD_COUNT-1:0] pads_reg;
    logic [TIME_W-1:0]    now_reg;
    logic                 flush_reg;

    logic [PAD_COUNT-1:0] was_reg;
    logic [PAD_COUNT-1:0] snd_reg;
    logic [TIME_W-1:0]    end_reg [PAD_COUNT];
    logic [TIME_W-1:0]    grd_reg [PAD_COUNT];
    logic [TIME_W-1:0]    prv_reg [PAD_COUNT];

    logic              pend_valid_reg, pend_valid_next;
    msg_t              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    msg_t              out_reg, out_next;
    logic              out_last_reg, out_last_next;

    alu_req_t          alu_req;
    logic [TIME_W-1:0] alu_sum;
    logic              alu_ge;

    logic              emit_req;
    msg_t              emit_msg;
    logic              out_free;
    logic              can_emit;
    logic              stall;
    logic              push;
    logic              pressed;
    logic              pad_last;
    logic              wr_was, wr_snd, snd_val, wr_hit, wr_grd, clr_all;
    logic              cfg_wr;
    logic              in_fire;

    dpmt_alu u_alu (
        .req (alu_req),
        .sum (alu_sum),
        .ge  (alu_ge)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg  <= 4'd9;
            nvel_reg  <= 7'd100;
            avel_reg  <= 7'd120;
            len_reg   <= 16'd45;
            grdms_reg <= 16'd20;
            win_reg   <= 16'd120;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MIDI_CHANNEL: chan_reg  <= pwdata[3:0];
                REG_NORMAL_VEL:   nvel_reg  <= pwdata[6:0];
                REG_ACCENT_VEL:   avel_reg  <= pwdata[6:0];
                REG_NOTE_LENGTH:  len_reg   <= pwdata[MS_W-1:0];
                REG_GUARD:        grdms_reg <= pwdata[MS_W-1:0];
                REG_ACCENT_WIN:   win_reg   <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MIDI_CHANNEL: prdata = {28'd0, chan_reg};
            REG_NORMAL_VEL:   prdata = {25'd0, nvel_reg};
            REG_ACCENT_VEL:   prdata = {25'd0, avel_reg};
            REG_NOTE_LENGTH:  prdata = {16'd0, len_reg};
            REG_GUARD:        prdata = {16'd0, grdms_reg};
            REG_ACCENT_WIN:   prdata = {16'd0, win_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign s_ready  = (state_reg == {1'b0, ST_IDLE});
    assign in_fire  = s_valid && s_ready;
    assign pressed  = pads_reg[pad_reg];
    assign pad_last = (pad_reg == PAD_W'(PAD_COUNT - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign can_emit = !pend_valid_reg || out_free;

    always_comb begin
        alu_req.a   = now_reg;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        case (state_reg[2:0])
            ST_GUARD: begin
                alu_req.b   = grd_reg[pad_reg];
                alu_req.sub = 1'b1;
            end
            ST_ACC: begin
                alu_req.b   = prv_reg[pad_reg];
                alu_req.sub = 1'b1;
            end
            ST_ON: alu_req.b = {{(TIME_W-MS_W){1'b0}}, len_reg};
            ST_GSET: alu_req.b = {{(TIME_W-MS_W){1'b0}}, grdms_reg};
            ST_END: begin
                alu_req.b   = end_reg[pad_reg];
                alu_req.sub = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        done_next       = done_reg;
        pad_next        = pad_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        emit_req        = 1'b0;
        emit_msg.status = {STATUS_NOTE_OFF, chan_reg};
        emit_msg.note   = pad_note(pad_reg);
        emit_msg.vel    = 7'd0;
        wr_was          = 1'b0;
        wr_snd          = 1'b0;
        snd_val         = 1'b0;
        wr_hit          = 1'b0;
        wr_grd          = 1'b0;
        clr_all         = 1'b0;

        if (state_reg == {1'b0, ST_IDLE}) begin
            if (in_fire) begin
                state_next = {1'b0, ST_GUARD};
                pad_next   = '0;
                cnt_next   = '0;
            end
        end else if (done_reg) begin
            if (!pend_valid_reg) begin
                state_next = {1'b0, ST_IDLE};
                done_next  = 1'b0;
            end else if (out_free) begin
                m_valid_next    = 1'b1;
                out_next        = pend_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = {1'b0, ST_IDLE};
                done_next       = 1'b0;
            end
        end else begin
            case (state_reg[2:0])
                ST_GUARD: begin
                    state_next = (pressed && !was_reg[pad_reg] && alu_ge) ?
                                 {1'b0, ST_ACC} : {1'b0, ST_END};
                end
                ST_ACC: begin
                    acc_next = (prv_reg[pad_reg] != '0) &&
                               (alu_sum <= {{(TIME_W-MS_W){1'b0}}, win_reg});
                    state_next = {1'b0, ST_OFF1};
                end
                ST_OFF1: begin
                    emit_req = snd_reg[pad_reg];
                    state_next = {1'b0, ST_ON};
                end
                ST_ON: begin
                    emit_req = 1'b1;
                    emit_msg.status = {STATUS_NOTE_ON, chan_reg};
                    emit_msg.vel = acc_reg ? avel_reg : nvel_reg;
                    wr_hit = 1'b1;
                    state_next = {1'b0, ST_GSET};
                end
                ST_GSET: begin
                    wr_grd = 1'b1;
                    state_next = {1'b0, ST_END};
                end
                ST_END: begin
                    emit_req = snd_reg[pad_reg] && alu_ge;
                    wr_snd   = snd_reg[pad_reg] && alu_ge;
                    wr_was   = 1'b1;
                    if (pad_last) begin
                        pad_next = '0;
                        if (flush_reg) begin
                            state_next = {1'b0, ST_FLUSH};
                        end else begin
                            done_next = 1'b1;
                        end
                    end else begin
                        pad_next   = pad_reg + 1'b1;
                        state_next = {1'b0, ST_GUARD};
                    end
                end
                ST_FLUSH: begin
                    emit_req = snd_reg[pad_reg] || was_reg[pad_reg];
                    if (pad_last) begin
                        clr_all   = 1'b1;
                        done_next = 1'b1;
                    end else begin
                        pad_next = pad_reg + 1'b1;
                    end
                end
                default: state_next = {1'b0, ST_IDLE};
            endcase
        end

        stall = emit_req && (cnt_reg != RESULT_LIMIT) && !can_emit;
        push  = emit_req && (cnt_reg != RESULT_LIMIT) && can_emit;

        if (stall) begin
            state_next = state_reg;
            done_next  = done_reg;
            pad_next   = pad_reg;
            wr_was     = 1'b0;
            wr_snd     = 1'b0;
            wr_hit     = 1'b0;
            clr_all    = 1'b0;
        end
        if (wr_hit) begin
            wr_snd  = 1'b1;
            snd_val = 1'b1;
        end
        if (push) begin
            cnt_next        = cnt_reg + 1'b1;
            pend_valid_next = 1'b1;
            pend_next       = emit_msg;
            if (pend_valid_reg) begin
                m_valid_next  = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= {1'b0, ST_IDLE};
            done_reg       <= 1'b0;
            pad_reg        <= '0;
            cnt_reg        <= '0;
            acc_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            pad_reg        <= pad_next;
            cnt_reg        <= cnt_next;
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (in_fire) begin
            pads_reg  <= s_pad_bits;
            now_reg   <= s_time_ms;
            flush_reg <= s_flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr_all) begin
            was_reg <= '0;
            snd_reg <= '0;
            for (int i = 0; i < PAD_COUNT; i++) begin
                end_reg[i] <= '0;
                grd_reg[i] <= '0;
                prv_reg[i] <= '0;
            end
        end else begin
            if (wr_was) begin
                was_reg[pad_reg] <= pressed;
            end
            if (wr_snd) begin
                snd_reg[pad_reg] <= snd_val;
            end
            if (wr_hit) begin
                prv_reg[pad_reg] <= now_reg;
                end_reg[pad_reg] <= alu_sum;
            end
            if (wr_grd) begin
                grd_reg[pad_reg] <= alu_sum;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status_byte  = out_reg.status;
    assign m_note_number  = out_reg.note;
    assign m_velocity     = out_reg.vel;
    assign m_last_message = out_last_reg;

    `ASSERT_CLK(a_pad_bound, aclk, aresetn, pad_reg <= PAD_W'(PAD_COUNT - 1), "pad index out of range")
    `ASSERT_CLK(a_cnt_bound, aclk, aresetn, cnt_reg <= RESULT_LIMIT, "message count over limit")
    `ASSERT_CLK(a_idle_clean, aclk, aresetn, s_ready |-> !pend_valid_reg, "held message while idle")
    `ASSERT_CLK(a_start_clean, aclk, aresetn, in_fire |=> (cnt_reg == '0 && !done_reg), "scan start not clean")
    `ASSERT_CLK(a_pend_counted, aclk, aresetn, pend_valid_reg |-> cnt_reg != '0, "held message not counted")

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the drum pad to MIDI trigger. A short table of
// directed scans covers pad extremes, retrigger guard, accents, time wrap,
// flush, message overflow and zero note length; random scans follow under
// several register settings. Each scan's MIDI messages, from a local
// pad-state predictor or a typed row, are compared beat by beat.
// ----------------------------------------------------------------------------
module tb_top;
    import dpmt_pkg::*;

    localparam int SETTLE_CYCLES = 120;
    localparam int LIMIT_TIME = 1000000;
    localparam int RANDOM_PHASES = 5;
    localparam int SCANS_PER_PHASE = 28;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [PAD_COUNT*7-1:0] DRUM_NOTES =
        {7'd51, 7'd43, 7'd47, 7'd36, 7'd50, 7'd38, 7'd44, 7'd42, 7'd49};

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] vel;
        logic       last;
    } midi_msg_t;

    typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [PAD_COUNT-1:0]   pads;
        logic [TIME_W-1:0]      t;
        logic                   f;
        logic                   typed;
        midi_msg_t              want;
        logic [2:0]             reg_idx;
        logic [31:0]            value;
    } row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [PAD_COUNT-1:0]   s_pad_bits = '0;
    logic [TIME_W-1:0]      s_time_ms = '0;
    logic                   s_flush = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_status_byte;
    logic [6:0]             m_note_number;
    logic [6:0]             m_velocity;
    logic                   m_last_message;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    logic [3:0]         cfg_channel = 4'd9;
    logic [6:0]         cfg_normal_vel = 7'd100;
    logic [6:0]         cfg_accent_vel = 7'd120;
    logic [MS_W-1:0]    cfg_note_len = 16'd45;
    logic [MS_W-1:0]    cfg_guard = 16'd20;
    logic [MS_W-1:0]    cfg_accent_win = 16'd120;

    logic               pad_down [PAD_COUNT];
    logic               pad_sounding [PAD_COUNT];
    logic [TIME_W-1:0]  note_end_ms [PAD_COUNT];
    logic [TIME_W-1:0]  guard_until [PAD_COUNT];
    logic [TIME_W-1:0]  prev_hit_ms [PAD_COUNT];

    midi_msg_t  scan_msgs [$];
    midi_msg_t  pending_msgs [$];
    row_t       plan [$];
    int         idle_pct = 36;
    int         mismatches = 0;
    int         scans_sent = 0;
    int         msgs_seen = 0;
    int         settings_used = 1;

    drum_pad_to_midi_trigger dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pad_bits     (s_pad_bits),
        .s_time_ms      (s_time_ms),
        .s_flush        (s_flush),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status_byte  (m_status_byte),
        .m_note_number  (m_note_number),
        .m_velocity     (m_velocity),
        .m_last_message (m_last_message),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Timeout with %0d MIDI beats still expected", pending_msgs.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function automatic void clear_pads();
        for (int i = 0; i < PAD_COUNT; i++) begin
            pad_down[i] = 1'b0;
            pad_sounding[i] = 1'b0;
            note_end_ms[i] = '0;
            guard_until[i] = '0;
            prev_hit_ms[i] = '0;
        end
    endfunction

    function automatic void add_msg(input logic [3:0] kind, input logic [6:0] note,
                                    input logic [6:0] vel);
        midi_msg_t m;
        if (scan_msgs.size() < int'(RESULT_LIMIT)) begin
            m.status = {kind, cfg_channel};
            m.note = note;
            m.vel = vel;
            m.last = 1'b0;
            scan_msgs.push_back(m);
        end
    endfunction

    function automatic void predict_scan(input logic [PAD_COUNT-1:0] pads,
                                         input logic [TIME_W-1:0] t, input logic f);
        logic [6:0]         note;
        logic [6:0]         vel;
        logic [TIME_W-1:0]  gap;
        scan_msgs.delete();
        for (int i = 0; i < PAD_COUNT; i++) begin
            note = DRUM_NOTES[i*7 +: 7];
            if (pads[i] && !pad_down[i] && t >= guard_until[i]) begin
                gap = t - prev_hit_ms[i];
                vel = cfg_normal_vel;
                if (prev_hit_ms[i] != '0 && gap <= {16'd0, cfg_accent_win}) begin
                    vel = cfg_accent_vel;
                end
                if (pad_sounding[i]) add_msg(STATUS_NOTE_OFF, note, 7'd0);
                add_msg(STATUS_NOTE_ON, note, vel);
                pad_sounding[i] = 1'b1;
                note_end_ms[i] = t + {16'd0, cfg_note_len};
                guard_until[i] = t + {16'd0, cfg_guard};
                prev_hit_ms[i] = t;
            end
            if (pad_sounding[i] && t >= note_end_ms[i]) begin
                add_msg(STATUS_NOTE_OFF, note, 7'd0);
                pad_sounding[i] = 1'b0;
            end
            pad_down[i] = pads[i];
        end
        if (f) begin
            for (int i = 0; i < PAD_COUNT; i++) begin
                if (pad_sounding[i] || pad_down[i]) begin
                    add_msg(STATUS_NOTE_OFF, DRUM_NOTES[i*7 +: 7], 7'd0);
                end
            end
            clear_pads();
        end
        if (scan_msgs.size() > 0) scan_msgs[scan_msgs.size()-1].last = 1'b1;
    endfunction

    function automatic row_t scan_row(input logic [PAD_COUNT-1:0] pads,
                                      input logic [TIME_W-1:0] t, input logic f);
        row_t r;
        r = '0;
        r.kind = ROW_SCAN;
        r.pads = pads;
        r.t = t;
        r.f = f;
        return r;
    endfunction

    function automatic row_t typed_row(input logic [PAD_COUNT-1:0] pads,
                                       input logic [TIME_W-1:0] t, input logic [3:0] kind,
                                       input logic [6:0] note, input logic [6:0] vel);
        row_t r;
        r = scan_row(pads, t, 1'b0);
        r.typed = 1'b1;
        r.want.status = {kind, 4'd9};
        r.want.note = note;
        r.want.vel = vel;
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [2:0] idx, input logic [31:0] value);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge aclk) begin
        midi_msg_t want;
        if (aresetn && m_valid && m_ready) begin
            msgs_seen++;
            if (pending_msgs.size() == 0) begin
                report_mismatch($sformatf("unexpected beat status=%02h note=%0d vel=%0d",
                                          m_status_byte, m_note_number, m_velocity));
            end else begin
                want = pending_msgs.pop_front();
                if (m_status_byte !== want.status)
                    report_mismatch($sformatf("status_byte %02h, expected %02h",
                                              m_status_byte, want.status));
                if (m_note_number !== want.note)
                    report_mismatch($sformatf("note_number %0d, expected %0d",
                                              m_note_number, want.note));
                if (m_velocity !== want.vel)
                    report_mismatch($sformatf("velocity %0d, expected %0d",
                                              m_velocity, want.vel));
                if (m_last_message !== want.last)
                    report_mismatch($sformatf("last_message %0b, expected %0b",
                                              m_last_message, want.last));
            end
        end
    end

    task automatic send_scan(input row_t r);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pad_bits <= r.pads;
        s_time_ms <= r.t;
        s_flush <= r.f;
        do @(posedge aclk); while (!s_ready);
        scans_sent++;
        predict_scan(r.pads, r.t, r.f);
        if (r.typed) begin
            pending_msgs.push_back(r.want);
        end else begin
            foreach (scan_msgs[k]) pending_msgs.push_back(scan_msgs[k]);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_MIDI_CHANNEL: cfg_channel = value[3:0];
            REG_NORMAL_VEL:   cfg_normal_vel = value[6:0];
            REG_ACCENT_VEL:   cfg_accent_vel = value[6:0];
            REG_NOTE_LENGTH:  cfg_note_len = value[15:0];
            REG_GUARD:        cfg_guard = value[15:0];
            REG_ACCENT_WIN:   cfg_accent_win = value[15:0];
            default: ;
        endcase
    endtask

    initial begin
        logic [PAD_COUNT-1:0]   pads;
        logic [TIME_W-1:0]      now_ms;
        int                     r;
        int                     directed_scans;

        clear_pads();
        plan.push_back(typed_row(9'h001, 32'd1000, STATUS_NOTE_ON, 7'd49, 7'd100));
        plan.push_back(scan_row(9'h000, 32'd1010, 1'b0));
        plan.push_back(scan_row(9'h001, 32'd1015, 1'b0));
        plan.push_back(typed_row(9'h000, 32'd1050, STATUS_NOTE_OFF, 7'd49, 7'd0));
        plan.push_back(typed_row(9'h001, 32'd1100, STATUS_NOTE_ON, 7'd49, 7'd120));
        plan.push_back(scan_row(9'h1FF, 32'd1110, 1'b0));
        plan.push_back(scan_row(9'h000, 32'd1111, 1'b1));
        plan.push_back(scan_row(9'h100, 32'hFFFF_FFF0, 1'b0));
        plan.push_back(scan_row(9'h000, 32'd5, 1'b0));
        plan.push_back(scan_row(9'h100, 32'd6, 1'b0));
        plan.push_back(scan_row(9'h000, 32'd0, 1'b1));
        plan.push_back(typed_row(9'h002, 32'd0, STATUS_NOTE_ON, 7'd42, 7'd100));
        plan.push_back(scan_row(9'h000, 32'd10, 1'b0));
        plan.push_back(scan_row(9'h002, 32'd30, 1'b0));
        plan.push_back(scan_row(9'h010, 32'hFFFF_FFFF, 1'b0));
        plan.push_back(scan_row(9'h000, 32'hFFFF_FF00, 1'b1));
        plan.push_back(scan_row(9'h1FF, 32'hFFFF_FF00, 1'b0));
        plan.push_back(scan_row(9'h000, 32'hFFFF_FF01, 1'b0));
        plan.push_back(scan_row(9'h1FF, 32'hFFFF_FFF0, 1'b1));
        plan.push_back(cfg_row(REG_NOTE_LENGTH, 32'd0));
        plan.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
        plan.push_back(scan_row(9'h0AA, 32'd500, 1'b0));
        plan.push_back(scan_row(9'h155, 32'd501, 1'b1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(plan[k].reg_idx, plan[k].value);
                psel <= 1'b0;
                penable <= 1'b0;
                settings_used++;
            end else begin
                send_scan(plan[k]);
            end
        end
        directed_scans = scans_sent;

        pads = '0;
        now_ms = 32'd2000;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            idle_pct = (phase == 2) ? 0 : 36;
            case (phase)
                0: begin
                    write_reg(REG_MIDI_CHANNEL, 32'd15);
                    write_reg(REG_NORMAL_VEL, 32'd127);
                    write_reg(REG_ACCENT_VEL, 32'd0);
                    write_reg(REG_NOTE_LENGTH, 32'd0);
                    write_reg(REG_GUARD, 32'd0);
                    write_reg(REG_ACCENT_WIN, 32'd65535);
                end
                1: begin
                    write_reg(REG_MIDI_CHANNEL, 32'd0);
                    write_reg(REG_NORMAL_VEL, 32'd0);
                    write_reg(REG_ACCENT_VEL, 32'd127);
                    write_reg(REG_NOTE_LENGTH, 32'd65535);
                    write_reg(REG_GUARD, 32'd65535);
                    write_reg(REG_ACCENT_WIN, 32'd0);
                end
                default: begin
                    write_reg(REG_MIDI_CHANNEL, $urandom_range(0, 15));
                    write_reg(REG_NORMAL_VEL, $urandom_range(0, 127));
                    write_reg(REG_ACCENT_VEL, $urandom_range(0, 127));
                    write_reg(REG_NOTE_LENGTH, $urandom_range(0, 80));
                    write_reg(REG_GUARD, $urandom_range(0, 30));
                    write_reg(REG_ACCENT_WIN, $urandom_range(0, 150));
                    write_reg(REG_UNUSED, $urandom);
                end
            endcase
            psel <= 1'b0;
            penable <= 1'b0;
            settings_used++;
            for (int n = 0; n < SCANS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 80) now_ms = now_ms + $urandom_range(0, 40);
                else if (r < 88) now_ms = $urandom;
                else if (r < 94) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 80);
                else now_ms = now_ms - $urandom_range(0, 50);
                if ($urandom_range(0, 99) < 70)
                    pads = pads ^ (9'($urandom_range(0, 511)) & 9'($urandom_range(0, 511)));
                else
                    pads = 9'($urandom_range(0, 511));
                send_scan(scan_row(pads, now_ms, $urandom_range(0, 11) == 0));
            end
        end

        wait_idle();
        $display("Sent %0d pad scans (%0d directed) under %0d register settings,",
                 scans_sent, directed_scans, settings_used);
        $display("and checked %0d MIDI message beats with %0d mismatches.",
                 msgs_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
